FILE: hdl/diit_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diit_pkg: shared types and constants
// Widths, opcodes and the front-to-back command record of the interning table.
// ----------------------------------------------------------------------------
package diit_pkg;
    localparam int TableEntries = 256;
    localparam int IdBits       = 8;
    localparam int CountBits    = 9;
    localparam int ItemBits     = 16;
    localparam int KeyBits      = 32;
    localparam int QueueDepth   = 2;

    localparam logic [1:0] OpTranslate = 2'd0;
    localparam logic [1:0] OpQuery     = 2'd1;
    localparam logic [1:0] OpRetrieve  = 2'd2;
    localparam logic [1:0] OpClear     = 2'd3;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [ItemBits-1:0] item_index;
        logic [KeyBits-1:0]  key_value;
        logic [IdBits-1:0]   id_in;
    } t_cmd;

    typedef struct packed {
        logic [IdBits-1:0]    id_out;
        logic                 found;
        logic                 is_new;
        logic                 error_flag;
        logic [ItemBits-1:0]  item_out;
        logic [KeyBits-1:0]   key_out;
        logic [CountBits-1:0] entry_count;
    } t_res;
endpackage
`default_nettype wire

FILE: hdl/diit_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diit_front: command queue
// Accepts items and holds them until the back end takes them.
// ----------------------------------------------------------------------------
module diit_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  diit_pkg::t_cmd   i_cmd,
    output logic             o_full,
    output logic             o_valid,
    output diit_pkg::t_cmd   o_cmd,
    input  wire              i_take
);
    diit_pkg::t_cmd r_q [diit_pkg::QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic do_push, do_take;

    assign o_full  = (r_cnt == 2'(diit_pkg::QueueDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_take);
        end
    end
endmodule
`default_nettype wire

FILE: hdl/diit_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diit_back: lookup engine
// Scans the pair memory one entry at a time (StScan, then StChk) and builds the result.
// ----------------------------------------------------------------------------
module diit_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  diit_pkg::t_cmd   i_cmd,
    output logic             o_take,
    output logic             o_res_valid,
    output diit_pkg::t_res   o_res,
    input  wire              i_res_pop
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StScan = 3'd1;
    localparam logic [2:0] StChk  = 3'd2;
    localparam logic [2:0] StRead = 3'd3;
    localparam logic [2:0] StDone = 3'd4;
    localparam int PairBits = diit_pkg::ItemBits + diit_pkg::KeyBits;

    logic [PairBits-1:0] r_mem [diit_pkg::TableEntries];
    logic [PairBits-1:0] r_rd;
    logic [2:0] r_st;
    diit_pkg::t_cmd r_cmd;
    logic [diit_pkg::CountBits-1:0] r_count, r_idx;
    diit_pkg::t_res r_res;
    diit_pkg::t_res r_out;
    logic r_out_v;
    logic hit, out_free;
    diit_pkg::t_res n_res;
    logic [diit_pkg::CountBits-1:0] n_count;

    assign out_free    = !r_out_v || i_res_pop;
    assign o_take      = (r_st == StIdle) && i_valid;
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;
    assign hit = (r_rd == {r_cmd.item_index, r_cmd.key_value});

    // final result and count of the command in StDone
    always_comb begin
        n_res   = r_res;
        n_count = r_count;
        unique case (r_cmd.opcode)
            diit_pkg::OpClear: begin
                n_count = '0;
            end
            diit_pkg::OpTranslate: begin
                if (!r_res.found) begin
                    if (r_count != 9'(diit_pkg::TableEntries)) begin
                        n_res.is_new = 1'b1;
                        n_res.id_out = r_count[diit_pkg::IdBits-1:0];
                        n_count      = r_count + 9'd1;
                    end else begin
                        n_res.error_flag = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        n_res.entry_count = n_count;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_idx[diit_pkg::IdBits-1:0]];
        if (r_st == StDone && out_free && n_res.is_new) begin
            r_mem[r_count[diit_pkg::IdBits-1:0]] <= {r_cmd.item_index, r_cmd.key_value};
        end
        if (!i_rst_n) begin
            r_st    <= StIdle;
            r_count <= '0;
            r_out_v <= 1'b0;
            r_cmd   <= '0;
        end else begin
            if (r_st == StDone && out_free) begin
                r_out_v <= 1'b1;
                r_out   <= n_res;
                r_count <= n_count;
            end else if (i_res_pop) begin
                r_out_v <= 1'b0;
            end
            unique case (r_st)
                StIdle: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_res <= '0;
                        r_idx <= (i_cmd.opcode == diit_pkg::OpRetrieve) ?
                                 9'(i_cmd.id_in) : '0;
                        r_st  <= (i_cmd.opcode == diit_pkg::OpClear) ? StDone : StScan;
                    end
                end
                StScan: begin
                    // memory read in flight for r_idx
                    if (r_cmd.opcode == diit_pkg::OpRetrieve) r_st <= StRead;
                    else if (r_idx >= r_count) r_st <= StDone;
                    else r_st <= StChk;
                end
                StChk: begin
                    if (hit) begin
                        r_res.found  <= 1'b1;
                        r_res.id_out <= r_idx[diit_pkg::IdBits-1:0];
                        r_st <= StDone;
                    end else begin
                        r_idx <= r_idx + 9'd1;
                        r_st  <= StScan;
                    end
                end
                StRead: begin
                    if (r_idx < r_count) begin
                        r_res.item_out <= r_rd[PairBits-1:diit_pkg::KeyBits];
                        r_res.key_out  <= r_rd[diit_pkg::KeyBits-1:0];
                    end else begin
                        r_res.error_flag <= 1'b1;
                    end
                    r_st <= StDone;
                end
                StDone: begin
                    if (out_free) begin
                        r_st <= StIdle;
                    end
                end
                default: r_st <= StIdle;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/dense_id_interning_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dense_id_interning_table_unit: dense identifier interning table
// Gives each distinct (item, key) pair a sequential id; query, retrieve, clear.
// ----------------------------------------------------------------------------
// channel  | handshake          | fields
// input    | i_push / o_full    | opcode, item_index, key_value, id_in
// result   | o_empty / i_pop    | id_out, found, is_new, error_flag,
//          |                    | item_out, key_out, entry_count
//
// Scanning: translate/query walk the stored pairs one entry at a time, each
// entry through StScan and StChk; retrieve reads one entry (StScan, StRead)
// and clear goes straight to StDone. A registered memory read lies between.
// Reset clears the count, queue and output register; the pair memory is not
// cleared. A two-entry command queue takes items while the engine scans, and
// a held result only stalls the engine's final step.
// ----------------------------------------------------------------------------
module dense_id_interning_table_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    output logic        o_full,
    input  wire  [1:0]  i_opcode,
    input  wire  [15:0] i_item_index,
    input  wire  [31:0] i_key_value,
    input  wire  [7:0]  i_id_in,
    output logic        o_empty,
    input  wire         i_pop,
    output logic [7:0]  o_id_out,
    output logic        o_found,
    output logic        o_is_new,
    output logic        o_error_flag,
    output logic [15:0] o_item_out,
    output logic [31:0] o_key_out,
    output logic [8:0]  o_entry_count
);
    diit_pkg::t_cmd in_cmd, q_cmd;
    diit_pkg::t_res res;
    logic q_valid, q_take, res_valid;

    assign in_cmd = '{opcode: i_opcode, item_index: i_item_index,
                      key_value: i_key_value, id_in: i_id_in};

    diit_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_cmd(in_cmd),
        .o_full(o_full), .o_valid(q_valid), .o_cmd(q_cmd), .i_take(q_take)
    );

    diit_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_cmd(q_cmd),
        .o_take(q_take), .o_res_valid(res_valid), .o_res(res),
        .i_res_pop(i_pop && !o_empty)
    );

    assign o_empty       = !res_valid;
    assign o_id_out      = res.id_out;
    assign o_found       = res.found;
    assign o_is_new      = res.is_new;
    assign o_error_flag  = res.error_flag;
    assign o_item_out    = res.item_out;
    assign o_key_out     = res.key_out;
    assign o_entry_count = res.entry_count;

    a_new_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> !(o_is_new && o_found)) else $error("new and found together");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> o_entry_count <= 9'd256) else $error("count out of range");
    a_new_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_is_new) |-> (o_entry_count == {1'b0, o_id_out} + 9'd1))
        else $error("new id mismatch");
endmodule
`default_nettype wire
